/* hdl/rotation_vector_to_quaternion_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the rotation vector to quaternion unit
// Short forms for concurrent assertions clocked on a rising edge, with and
// without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ROTATION_VECTOR_TO_QUATERNION_UNIT_MACROS_SVH
`define ROTATION_VECTOR_TO_QUATERNION_UNIT_MACROS_SVH

// Checked only while the active-low reset is released.
`define RVQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RVQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/rvq_pkg.sv */
// ----------------------------------------------------------------------------
// Rotation vector to quaternion package
// Types and constants shared by the stages of the conversion pipeline.
// ----------------------------------------------------------------------------
package rvq_pkg;

  localparam logic [31:0] OneQ30 = 32'h4000_0000;

  typedef struct packed {
    logic [31:0] mx;
    logic [31:0] my;
    logic [31:0] mz;
    logic        nx;
    logic        ny;
    logic        nz;
  } vec_t;

  typedef struct packed {
    logic [30:0] sm;
    logic [30:0] cm;
    logic        sneg;
    logic        cneg;
  } trig_t;

endpackage

/* hdl/rotation_vector_to_quaternion_unit.sv */
// ----------------------------------------------------------------------------
// Rotation vector to quaternion unit
// Throughput: one vector per cycle while the output is not stalled; every
// stage is a register, and a stalled output freezes the whole pipeline so
// that nothing is lost or repeated. The square root (32 stages) and the
// component divider (a product stage and 31 quotient stages) set the depth.
// Reset clears only the valid bits; the data path holds no state between items.
// ----------------------------------------------------------------------------
module rotation_vector_to_quaternion_unit import rvq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] rot_x_i,
  input  logic signed [31:0] rot_y_i,
  input  logic signed [31:0] rot_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] quat_first_o,
  output logic signed [31:0] quat_second_o,
  output logic signed [31:0] quat_third_o,
  output logic signed [31:0] quat_fourth_o
);

  logic        en;
  logic        out_vld_q;
  vec_t        vin;
  vec_t        s0_vec_q;
  vec_t        s1_vec_q;
  vec_t        s2_vec_q;
  logic        s0_vld_q;
  logic        s1_vld_q;
  logic        s2_vld_q;
  logic [63:0] s1_sqx_q;
  logic [63:0] s1_sqy_q;
  logic [63:0] s1_sqz_q;
  logic [63:0] s2_sum_q;

  logic        sq_vld;
  logic [31:0] sq_root;
  vec_t        sq_vec;
  logic        sc_vld;
  logic [31:0] sc_r;
  vec_t        sc_vec;
  trig_t       sc_trig;
  logic        dv_vld;
  logic [31:0] dv_r;
  vec_t        dv_vec;
  trig_t       dv_trig;
  logic [30:0] dv_qx;
  logic [30:0] dv_qy;
  logic [30:0] dv_qz;

  logic [31:0] first_d;
  logic [31:0] second_d;
  logic [31:0] third_d;
  logic [31:0] fourth_d;
  logic [31:0] first_q;
  logic [31:0] second_q;
  logic [31:0] third_q;
  logic [31:0] fourth_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    vin.nx = rot_x_i[31];
    vin.ny = rot_y_i[31];
    vin.nz = rot_z_i[31];
    vin.mx = rot_x_i[31] ? 32'd0 - $unsigned(rot_x_i) : $unsigned(rot_x_i);
    vin.my = rot_y_i[31] ? 32'd0 - $unsigned(rot_y_i) : $unsigned(rot_y_i);
    vin.mz = rot_z_i[31] ? 32'd0 - $unsigned(rot_z_i) : $unsigned(rot_z_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q  <= in_valid_i;
      s1_vld_q  <= s0_vld_q;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_vec_q <= vin;
      s1_vec_q <= s0_vec_q;
      s1_sqx_q <= {32'd0, s0_vec_q.mx} * {32'd0, s0_vec_q.mx};
      s1_sqy_q <= {32'd0, s0_vec_q.my} * {32'd0, s0_vec_q.my};
      s1_sqz_q <= {32'd0, s0_vec_q.mz} * {32'd0, s0_vec_q.mz};
      s2_vec_q <= s1_vec_q;
      s2_sum_q <= s1_sqx_q + s1_sqy_q + s1_sqz_q;
      first_q  <= first_d;
      second_q <= second_d;
      third_q  <= third_d;
      fourth_q <= fourth_d;
    end
  end

  rvq_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s2_vld_q),
    .sum_i  (s2_sum_q),
    .vec_i  (s2_vec_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .vec_o  (sq_vec)
  );

  rvq_sincos u_sincos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sq_vld),
    .r_i    (sq_root),
    .vec_i  (sq_vec),
    .vld_o  (sc_vld),
    .r_o    (sc_r),
    .vec_o  (sc_vec),
    .trig_o (sc_trig)
  );

  rvq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sc_vld),
    .r_i    (sc_r),
    .vec_i  (sc_vec),
    .trig_i (sc_trig),
    .vld_o  (dv_vld),
    .r_o    (dv_r),
    .vec_o  (dv_vec),
    .trig_o (dv_trig),
    .qx_o   (dv_qx),
    .qy_o   (dv_qy),
    .qz_o   (dv_qz)
  );

  // A zero vector gives the identity rotation.
  always_comb begin
    if (dv_r == '0) begin
      first_d  = OneQ30;
      second_d = '0;
      third_d  = '0;
      fourth_d = '0;
    end else begin
      first_d  = dv_trig.cneg ? 32'd0 - {1'b0, dv_trig.cm} : {1'b0, dv_trig.cm};
      second_d = (dv_trig.sneg ^ dv_vec.nz) ? 32'd0 - {1'b0, dv_qz} : {1'b0, dv_qz};
      third_d  = (dv_trig.sneg ^ dv_vec.ny) ? {1'b0, dv_qy} : 32'd0 - {1'b0, dv_qy};
      fourth_d = (dv_trig.sneg ^ dv_vec.nx) ? {1'b0, dv_qx} : 32'd0 - {1'b0, dv_qx};
    end
  end

  assign out_valid_o   = out_vld_q;
  assign quat_first_o  = $signed(first_q);
  assign quat_second_o = $signed(second_q);
  assign quat_third_o  = $signed(third_q);
  assign quat_fourth_o = $signed(fourth_q);

endmodule

/* hdl/rvq_sqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring square root of a 64-bit sum, one root bit per register stage.
// ----------------------------------------------------------------------------
module rvq_sqrt import rvq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [63:0] sum_i,
  input  vec_t        vec_i,
  output logic        vld_o,
  output logic [31:0] root_o,
  output vec_t        vec_o
);

  localparam int unsigned RootW = 32;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
    vec_t        vec;
  } sq_t;

  sq_t        st  [RootW+1];
  logic [RootW:0] vld;

  assign st[0].rem  = sum_i;
  assign st[0].root = '0;
  assign st[0].vec  = vec_i;
  assign vld[0]     = vld_i;

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    localparam int unsigned B = RootW - 1 - s;
    sq_t         st_d;
    sq_t         st_q;
    logic        v_q;
    logic [65:0] trial;
    logic        ge;

    always_comb begin
      trial = ({34'd0, st[s].root} << (B + 1)) | (66'd1 << (2 * B));
      ge    = {2'd0, st[s].rem} >= trial;
      st_d  = st[s];
      if (ge) begin
        st_d.rem  = st[s].rem - trial[63:0];
        st_d.root = st[s].root | (32'd1 << B);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q <= st_d;
      end
    end

    assign st[s+1]  = st_q;
    assign vld[s+1] = v_q;
  end

  assign vld_o  = vld[RootW];
  assign root_o = st[RootW].root;
  assign vec_o  = st[RootW].vec;

endmodule

/* hdl/rvq_sincos.sv */
// ----------------------------------------------------------------------------
// Pipelined half-angle sine and cosine
// Phase scaling, octant reduction, two Horner series lanes with constant
// divisions by reciprocal, and quadrant correction.
// ----------------------------------------------------------------------------
module rvq_sincos import rvq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [31:0] r_i,
  input  vec_t        vec_i,
  output logic        vld_o,
  output logic [31:0] r_o,
  output vec_t        vec_o,
  output trig_t       trig_o
);

  localparam int unsigned SerN   = 6;
  localparam int unsigned FrontN = 5;
  localparam logic [31:0] OneQ31 = 32'h8000_0000;
  localparam logic [31:0] PhaseK = 32'd1367130551;
  localparam logic [31:0] PiQ29  = 32'd1686629713;
  localparam logic [7:0]  SIN_DIV [SerN] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0]  COS_DIV [SerN] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [31:0] SIN_RCP [SerN] = '{32'd27531841, 32'd39045157, 32'd59652323,
                                             32'd102261126, 32'd214748364, 32'd715827882};
  localparam logic [31:0] COS_RCP [SerN] = '{32'd32537631, 32'd47721858, 32'd76695844,
                                             32'd143165576, 32'd357913941, 32'd2147483648};

  typedef struct packed {
    logic [31:0] r;
    vec_t        vec;
    logic [1:0]  quad;
    logic        swap;
    logic [29:0] g;
    logic [31:0] a;
    logic [31:0] x2;
    logic [31:0] ts;
    logic [31:0] tc;
    logic [31:0] ms;
    logic [31:0] mc;
    logic [63:0] ps;
    logic [63:0] pc;
  } sc_t;

  function automatic logic [31:0] mul_q31(input logic [31:0] u, input logic [31:0] v);
    logic [63:0] p;
    p = ({32'd0, u} * {32'd0, v}) + 64'h0000_0000_4000_0000;
    return p[62:31];
  endfunction

  sc_t               fd [FrontN];
  sc_t               fq [FrontN];
  logic [FrontN-1:0] fv_q;

  always_comb begin
    logic [63:0] sum;
    logic [29:0] f;
    logic [30:0] gw;
    fd[0]     = '0;
    fd[0].r   = r_i;
    fd[0].vec = vec_i;
    fd[0].ps  = {32'd0, r_i} * {32'd0, PhaseK};

    sum        = fq[0].ps + 64'd33554432;
    f          = sum[55:26];
    fd[1]      = fq[0];
    fd[1].quad = sum[57:56];
    fd[1].swap = f > 30'h2000_0000;
    gw         = 31'h4000_0000 - {1'b0, f};
    fd[1].g    = fd[1].swap ? gw[29:0] : f;

    fd[2]    = fq[1];
    fd[2].ps = {34'd0, fq[1].g} * {32'd0, PiQ29};

    sum     = fq[2].ps + 64'd268435456;
    fd[3]   = fq[2];
    fd[3].a = sum[60:29];

    fd[4]    = fq[3];
    fd[4].x2 = mul_q31(fq[3].a, fq[3].a);
    fd[4].ts = OneQ31;
    fd[4].tc = OneQ31;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (en_i) begin
      fv_q <= {fv_q[FrontN-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < FrontN; k++) begin
        fq[k] <= fd[k];
      end
    end
  end

  sc_t         it  [SerN+1];
  logic [SerN:0] iv;

  assign it[0] = fq[FrontN-1];
  assign iv[0] = fv_q[FrontN-1];

  for (genvar k = 0; k < SerN; k++) begin : g_term
    sc_t         a_d;
    sc_t         a_q;
    sc_t         b_d;
    sc_t         b_q;
    sc_t         c_d;
    sc_t         c_q;
    logic [2:0]  v_q;
    logic [31:0] qs0;
    logic [31:0] qc0;
    logic [31:0] rs;
    logic [31:0] rc;
    logic [31:0] qs;
    logic [31:0] qc;

    always_comb begin
      a_d    = it[k];
      a_d.ms = mul_q31(it[k].x2, it[k].ts);
      a_d.mc = mul_q31(it[k].x2, it[k].tc);

      b_d    = a_q;
      b_d.ps = {32'd0, a_q.ms} * {32'd0, SIN_RCP[k]};
      b_d.pc = {32'd0, a_q.mc} * {32'd0, COS_RCP[k]};

      qs0    = b_q.ps[63:32];
      qc0    = b_q.pc[63:32];
      rs     = b_q.ms - qs0 * {24'd0, SIN_DIV[k]};
      rc     = b_q.mc - qc0 * {24'd0, COS_DIV[k]};
      qs     = (rs >= {24'd0, SIN_DIV[k]}) ? qs0 + 32'd1 : qs0;
      qc     = (rc >= {24'd0, COS_DIV[k]}) ? qc0 + 32'd1 : qc0;
      c_d    = b_q;
      c_d.ts = OneQ31 - qs;
      c_d.tc = OneQ31 - qc;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= '0;
      end else if (en_i) begin
        v_q <= {v_q[1:0], iv[k]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q <= a_d;
        b_q <= b_d;
        c_q <= c_d;
      end
    end

    assign it[k+1] = c_q;
    assign iv[k+1] = v_q[2];
  end

  sc_t   e_d;
  sc_t   e_q;
  logic  ev_q;
  logic  ov_q;
  trig_t tr_d;
  trig_t tr_q;
  logic [31:0] or_q;
  vec_t  ovec_q;

  always_comb begin
    logic [31:0] s0;
    logic [31:0] c0;
    logic [31:0] sm;
    logic [31:0] cm;
    logic [32:0] sr;
    logic [32:0] cr;
    e_d    = it[SerN];
    e_d.ms = mul_q31(it[SerN].a, it[SerN].ts);
    e_d.mc = it[SerN].tc;

    s0 = e_q.swap ? e_q.mc : e_q.ms;
    c0 = e_q.swap ? e_q.ms : e_q.mc;
    sm = e_q.quad[0] ? c0 : s0;
    cm = e_q.quad[0] ? s0 : c0;
    sr = {1'b0, sm} + 33'd1;
    cr = {1'b0, cm} + 33'd1;
    tr_d.sm   = sr[31:1];
    tr_d.cm   = cr[31:1];
    tr_d.sneg = e_q.quad[1];
    tr_d.cneg = e_q.quad[1] ^ e_q.quad[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en_i) begin
      ev_q <= iv[SerN];
      ov_q <= ev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q    <= e_d;
      tr_q   <= tr_d;
      or_q   <= e_q.r;
      ovec_q <= e_q.vec;
    end
  end

  assign vld_o  = ov_q;
  assign r_o    = or_q;
  assign vec_o  = ovec_q;
  assign trig_o = tr_q;

endmodule

/* hdl/rvq_div.sv */
// ----------------------------------------------------------------------------
// Pipelined component divider
// Scales the sine magnitude by each vector component and divides the three
// rounded products by the angle, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rvq_div import rvq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [31:0] r_i,
  input  vec_t        vec_i,
  input  trig_t       trig_i,
  output logic        vld_o,
  output logic [31:0] r_o,
  output vec_t        vec_o,
  output trig_t       trig_o,
  output logic [30:0] qx_o,
  output logic [30:0] qy_o,
  output logic [30:0] qz_o
);

  localparam int unsigned QuotW = 31;
  localparam int unsigned Lanes = 3;

  typedef struct packed {
    logic [31:0]                  r;
    vec_t                         vec;
    trig_t                        trig;
    logic [Lanes-1:0][61:0]       num;
    logic [Lanes-1:0][QuotW-1:0]  quo;
  } dv_t;

  dv_t          st [QuotW+1];
  logic [QuotW:0] vld;
  dv_t          p_d;
  dv_t          p_q;
  logic         pv_q;

  always_comb begin
    logic [31:0] mag [Lanes];
    logic [62:0] prod;
    mag[0]    = vec_i.mx;
    mag[1]    = vec_i.my;
    mag[2]    = vec_i.mz;
    p_d.r     = r_i;
    p_d.vec   = vec_i;
    p_d.trig  = trig_i;
    p_d.quo   = '0;
    for (int j = 0; j < Lanes; j++) begin
      prod       = {32'd0, trig_i.sm} * {31'd0, mag[j]};
      prod       = prod + {32'd0, r_i[31:1]};
      p_d.num[j] = prod[61:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign st[0]  = p_q;
  assign vld[0] = pv_q;

  for (genvar s = 0; s < QuotW; s++) begin : g_stage
    localparam int unsigned B = QuotW - 1 - s;
    dv_t         st_d;
    dv_t         st_q;
    logic        v_q;
    logic [62:0] dsh;

    always_comb begin
      dsh  = {31'd0, st[s].r} << B;
      st_d = st[s];
      for (int j = 0; j < Lanes; j++) begin
        if ({1'b0, st[s].num[j]} >= dsh) begin
          st_d.num[j]    = st[s].num[j] - dsh[61:0];
          st_d.quo[j][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q <= st_d;
      end
    end

    assign st[s+1]  = st_q;
    assign vld[s+1] = v_q;
  end

  assign vld_o  = vld[QuotW];
  assign r_o    = st[QuotW].r;
  assign vec_o  = st[QuotW].vec;
  assign trig_o = st[QuotW].trig;
  assign qx_o   = st[QuotW].quo[0];
  assign qy_o   = st[QuotW].quo[1];
  assign qz_o   = st[QuotW].quo[2];

endmodule

/* hdl/rvq_checker.sv */
// ----------------------------------------------------------------------------
// Rotation vector to quaternion port checker
// Watches the unit ports for stall handling, reset and first-component range.
// ----------------------------------------------------------------------------
`include "rotation_vector_to_quaternion_unit_macros.svh"

module rvq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] quat_first_o,
  input logic signed [31:0] quat_second_o,
  input logic signed [31:0] quat_third_o,
  input logic signed [31:0] quat_fourth_o
);

  localparam logic signed [31:0] QuatMax = 32'sd1073741824;

  logic         out_stall;
  logic [127:0] quat_all;
  logic         first_ok;

  assign out_stall = out_valid_o && !out_ready_i;
  assign quat_all  = {quat_first_o, quat_second_o, quat_third_o, quat_fourth_o};
  assign first_ok  = (quat_first_o <= QuatMax) && (quat_first_o >= -QuatMax);

  `RVQ_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(quat_all), "Held result changed")
  `RVQ_ASSERT(a_stall_back, clk_i, rst_ni, out_stall |-> !in_ready_o, "Input taken while output stalled")
  `RVQ_ASSERT(a_empty_ready, clk_i, rst_ni, !out_valid_o |-> in_ready_o, "Input refused with output empty")
  `RVQ_ASSERT(a_first_range, clk_i, rst_ni, out_valid_o |-> first_ok, "First component out of range")
  `RVQ_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_o, "Result valid after reset")

endmodule

bind rotation_vector_to_quaternion_unit rvq_checker u_rvq_checker (.*);
